[hw/rtl/pwm_motor_speed_controller_top_defines.svh]
// assertion macros used by the port-level checker
`ifndef PWM_MOTOR_SPEED_CONTROLLER_TOP_DEFINES_SVH
`define PWM_MOTOR_SPEED_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define PMSC_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PMSC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/pmsc_pkg.sv]
// shared types and codes of the pwm motor speed controller
`default_nettype none

package pmsc_pkg;

   // item kinds
   localparam logic [1:0] KIND_TICK   = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_FASTER = 2'd2;
   localparam logic [1:0] KIND_SLOWER = 2'd3;

   // direction codes
   localparam logic [1:0] DIR_CW   = 2'd0;
   localparam logic [1:0] DIR_CCW  = 2'd1;
   localparam logic [1:0] DIR_NONE = 2'd2;

   // alarm codes
   localparam logic [1:0] ALARM_NORMAL = 2'd0;
   localparam logic [1:0] ALARM_WARN   = 2'd1;
   localparam logic [1:0] ALARM_OVER   = 2'd2;

   // register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WRAP_PERIOD = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WARN_LEVEL  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TRIP_LEVEL  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TRIP_COUNT  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_UP     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_DOWN   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TRIM_MAX    = 3'd6;

   localparam int CSR_DATA_BITS = 8;
   localparam int REQ_DATA_BITS = 16;

   // the over counter stops here
   localparam logic [7:0] OVER_MAX = 8'hFF;

   typedef struct packed {
      logic [7:0] wrap_period;
      logic [7:0] warn_level;
      logic [7:0] trip_level;
      logic [7:0] trip_count;
      logic [7:0] step_up;
      logic [7:0] step_down;
      logic [7:0] trim_max;
   } cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] adc_sample;
      logic       cw_select;
      logic       ccw_select;
   } item_type;

endpackage

`default_nettype wire

[hw/rtl/pmsc_csr.sv]
// configuration register file
`default_nettype none

module pmsc_csr
   import pmsc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                        cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_WRAP_PERIOD: cfg_in.wrap_period = csr_wdata;
            REG_WARN_LEVEL:  cfg_in.warn_level  = csr_wdata;
            REG_TRIP_LEVEL:  cfg_in.trip_level  = csr_wdata;
            REG_TRIP_COUNT:  cfg_in.trip_count  = csr_wdata;
            REG_STEP_UP:     cfg_in.step_up     = csr_wdata;
            REG_STEP_DOWN:   cfg_in.step_down   = csr_wdata;
            REG_TRIM_MAX:    cfg_in.trim_max    = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wrap_period <= 8'd254;
         cfg_ff.warn_level  <= 8'd245;
         cfg_ff.trip_level  <= 8'd252;
         cfg_ff.trip_count  <= 8'd100;
         cfg_ff.step_up     <= 8'd8;
         cfg_ff.step_down   <= 8'd2;
         cfg_ff.trim_max    <= 8'd128;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/pmsc_core.sv]
// controller state and the single-pass update for one item
`default_nettype none

module pmsc_core
   import pmsc_pkg::*;
#(
   parameter int SPEED_BITS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  item_valid,
   input  item_type                   item,
   input  cfg_type                    cfg,
   output logic [SPEED_BITS+6:0]      result
);

   localparam int CMP_BITS = (SPEED_BITS > 9) ? SPEED_BITS : 9;
   localparam logic [CMP_BITS-1:0] SPEED_MAX = CMP_BITS'((1 << SPEED_BITS) - 1);

   function automatic logic [1:0] classify(input logic [SPEED_BITS-1:0] s,
                                           input cfg_type c);
      logic [CMP_BITS-1:0] sx;
      sx = CMP_BITS'(s);
      if (sx >= CMP_BITS'(c.trip_level)) return ALARM_OVER;
      if (sx >= CMP_BITS'(c.warn_level)) return ALARM_WARN;
      return ALARM_NORMAL;
   endfunction

   logic [7:0]            cnt_ff, cnt_in;
   logic [7:0]            trim_ff, trim_in;
   logic [SPEED_BITS-1:0] speed_ff, speed_in;
   logic [1:0]            dir_ff, dir_in;
   logic [7:0]            over_ff, over_in;
   logic                  trip_ff, trip_in;

   logic [8:0]            cnt_next;
   logic [8:0]            up_sum;
   logic [CMP_BITS-1:0]   samp_sum;
   logic [SPEED_BITS-1:0] samp_speed;
   logic [1:0]            samp_band;
   logic                  pwm_on;

   assign cnt_next   = {1'b0, cnt_ff} + 9'd1;
   assign up_sum     = {1'b0, trim_ff} + {1'b0, cfg.step_up};
   assign samp_sum   = CMP_BITS'(item.adc_sample[7:1]) + CMP_BITS'(trim_ff);
   assign samp_speed = (samp_sum > SPEED_MAX) ? SPEED_MAX[SPEED_BITS-1:0]
                                              : samp_sum[SPEED_BITS-1:0];
   assign samp_band  = classify(samp_speed, cfg);

   always_comb begin
      cnt_in   = cnt_ff;
      trim_in  = trim_ff;
      speed_in = speed_ff;
      dir_in   = dir_ff;
      over_in  = over_ff;
      trip_in  = trip_ff;
      unique case (item.kind)
         KIND_TICK: begin
            cnt_in = (cnt_next >= {1'b0, cfg.wrap_period}) ? 8'd0 : cnt_next[7:0];
         end
         KIND_SAMPLE: begin
            if (trip_ff) begin
               dir_in = DIR_NONE;
            end else if (item.cw_select && !item.ccw_select) begin
               dir_in = DIR_CW;
            end else if (item.ccw_select && !item.cw_select) begin
               dir_in = DIR_CCW;
            end else begin
               dir_in = DIR_NONE;
            end
            if (samp_band == ALARM_OVER) begin
               over_in = (over_ff != OVER_MAX) ? over_ff + 8'd1 : over_ff;
            end else if (samp_band == ALARM_NORMAL) begin
               over_in = 8'd0;
            end
            if (over_in > cfg.trip_count) begin
               trip_in  = 1'b1;
               speed_in = '0;
               dir_in   = DIR_NONE;
            end else begin
               speed_in = samp_speed;
            end
         end
         KIND_FASTER: begin
            // presses only count while a direction is selected
            if (dir_ff != DIR_NONE) begin
               trim_in = (up_sum > {1'b0, cfg.trim_max}) ? cfg.trim_max : up_sum[7:0];
            end
         end
         KIND_SLOWER: begin
            trim_in = (trim_ff >= cfg.step_down) ? trim_ff - cfg.step_down : 8'd0;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   assign pwm_on = CMP_BITS'(cnt_in) < CMP_BITS'(speed_in);

   // drive_cw, drive_ccw, speed, dir, alarm, trip from the lowest bit up
   assign result = {trip_in,
                    classify(speed_in, cfg),
                    dir_in,
                    speed_in,
                    pwm_on && (dir_in == DIR_CCW),
                    pwm_on && (dir_in == DIR_CW)};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= 8'd0;
         trim_ff  <= 8'd0;
         speed_ff <= '0;
         dir_ff   <= DIR_NONE;
         over_ff  <= 8'd0;
         trip_ff  <= 1'b0;
      end else if (item_valid) begin
         cnt_ff   <= cnt_in;
         trim_ff  <= trim_in;
         speed_ff <= speed_in;
         dir_ff   <= dir_in;
         over_ff  <= over_in;
         trip_ff  <= trip_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/pwm_motor_speed_controller_top.sv]
// top level of the pwm motor speed controller with overspeed trip
// data path: an accepted transaction passes through the input register, then the
// state update and result register in one pass, before it shows on rsp
// throughput: one transaction per cycle while rsp is not stalled, set by the state update loop
// reset: synchronous, active high; clears state, channel valids and registers
// to their defaults, no clearing pass, the block accepts right after reset
`default_nettype none

module pwm_motor_speed_controller_top
   import pmsc_pkg::*;
#(
   parameter int SPEED_BITS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // adc_sample[7:0], cw_select[8], ccw_select[9], zero pad
   input  wire logic [REQ_DATA_BITS-1:0]      req_tdata,
   // kind[1:0]
   input  wire logic [1:0]                    req_tuser,
   // response channel
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // drive_cw, drive_ccw, speed_now, dir_code, alarm_level, trip_flag, zero pad
   output logic [((SPEED_BITS+14)/8)*8-1:0]   rsp_tdata,
   // configuration write channel
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int RES_BITS = SPEED_BITS + 7;
   localparam int RSP_BITS = ((SPEED_BITS + 14) / 8) * 8;

   cfg_type               cfg;
   item_type              req_item;
   logic [RES_BITS-1:0]   result;

   // input register
   logic                  in_valid_ff, in_valid_in;
   item_type              in_item_ff;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0]   rsp_data_ff;

   logic                  advance;
   logic                  req_fire;

   assign req_item.kind       = req_tuser;
   assign req_item.adc_sample = req_tdata[7:0];
   assign req_item.cw_select  = req_tdata[8];
   assign req_item.ccw_select = req_tdata[9];

   // the held transaction moves on when the result register is free or being drained
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_data_ff <= RSP_BITS'(result);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   pmsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // state update happens on the cycle the transaction leaves the input register
   pmsc_core #(
      .SPEED_BITS (SPEED_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (advance),
      .item       (in_item_ff),
      .cfg        (cfg),
      .result     (result)
   );

endmodule

`default_nettype wire

[hw/rtl/pmsc_checker.sv]
// port-level checker of the controller, bound to the top level
`default_nettype none
`include "pwm_motor_speed_controller_top_defines.svh"

module pmsc_checker
   import pmsc_pkg::*;
#(
   parameter int SPEED_BITS = 8
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [((SPEED_BITS+14)/8)*8-1:0] rsp_tdata
);

   localparam int DIR_LSB  = SPEED_BITS + 2;
   localparam int TRIP_BIT = SPEED_BITS + 6;

   logic                  drv_cw;
   logic                  drv_ccw;
   logic [SPEED_BITS-1:0] speed;
   logic [1:0]            dir;
   logic                  trip;

   assign drv_cw  = rsp_tdata[0];
   assign drv_ccw = rsp_tdata[1];
   assign speed   = rsp_tdata[SPEED_BITS+1:2];
   assign dir     = rsp_tdata[DIR_LSB+1:DIR_LSB];
   assign trip    = rsp_tdata[TRIP_BIT];

   `PMSC_ASSERT_IMPL(a_one_side, rsp_tvalid, !(drv_cw && drv_ccw), "both bridge sides driven")
   `PMSC_ASSERT_IMPL(a_trip_stop, rsp_tvalid && trip, (dir == DIR_NONE) && !drv_cw && !drv_ccw,
      "drive active after trip")
   `PMSC_ASSERT_IMPL(a_drive_speed, rsp_tvalid && (drv_cw || drv_ccw), speed != '0,
      "drive with zero speed")
   `PMSC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata),
      "stalled response changed")

endmodule

bind pwm_motor_speed_controller_top pmsc_checker #(
   .SPEED_BITS (SPEED_BITS)
) u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

[test/pmsc_checker.sv]
// response checker for the pwm motor speed controller: tracks the motor state and compares
`timescale 1ns / 100ps

module pmsc_tb_checker
   import pmsc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   input  wire logic                      req_tready,
   input  wire logic [REQ_DATA_BITS-1:0]  req_tdata,
   input  wire logic [1:0]                req_tuser,
   input  wire logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   input  wire logic [15:0]               rsp_tdata,
   input  wire logic                      csr_valid,
   input  wire logic                      csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                             fail_count,
   output int                             pending
);

   localparam logic [8:0] SPEED_MAX    = 9'd255;
   localparam int         REPORT_LIMIT = 20;

   // rsp_tdata layout, highest bit first
   typedef struct packed {
      logic       trip_flag;
      logic [1:0] alarm_level;
      logic [1:0] dir_code;
      logic [7:0] speed_now;
      logic       drive_ccw;
      logic       drive_cw;
   } motor_status_type;

   cfg_type          cfg;
   logic [7:0]       pwm_count;
   logic [7:0]       trim;
   logic [7:0]       speed_reg;
   logic [7:0]       over_count;
   logic [1:0]       dir_reg;
   logic             trip_latch;
   motor_status_type status_queue[$];

   task automatic report_mismatch(input string msg);
      if (fail_count < REPORT_LIMIT)
         $display("%0t ns: mismatch: %s", $time, msg);
      fail_count = fail_count + 1;
   endtask

   task automatic compare_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   function automatic logic [1:0] speed_band(input logic [7:0] s);
      if (s >= cfg.trip_level)
         return ALARM_OVER;
      if (s >= cfg.warn_level)
         return ALARM_WARN;
      return ALARM_NORMAL;
   endfunction

   // applies one transaction to the tracked state and returns the status it must produce
   function automatic motor_status_type advance_motor(input item_type it);
      logic [8:0]       sum;
      logic [1:0]       band;
      motor_status_type st;
      case (it.kind)
         KIND_TICK: begin
            sum = {1'b0, pwm_count} + 9'd1;
            pwm_count = (sum >= {1'b0, cfg.wrap_period}) ? 8'd0 : sum[7:0];
         end
         KIND_SAMPLE: begin
            if (trip_latch)
               dir_reg = DIR_NONE;
            else if (it.cw_select && !it.ccw_select)
               dir_reg = DIR_CW;
            else if (it.ccw_select && !it.cw_select)
               dir_reg = DIR_CCW;
            else
               dir_reg = DIR_NONE;
            sum = {2'b0, it.adc_sample[7:1]} + {1'b0, trim};
            speed_reg = (sum > SPEED_MAX) ? SPEED_MAX[7:0] : sum[7:0];
            band = speed_band(speed_reg);
            if (band == ALARM_OVER) begin
               if (over_count != OVER_MAX)
                  over_count = over_count + 8'd1;
            end else if (band == ALARM_NORMAL) begin
               over_count = 8'd0;
            end
            if (over_count > cfg.trip_count) begin
               trip_latch = 1'b1;
               speed_reg  = 8'd0;
               dir_reg    = DIR_NONE;
            end
         end
         KIND_FASTER: begin
            if (dir_reg != DIR_NONE) begin
               sum  = {1'b0, trim} + {1'b0, cfg.step_up};
               trim = (sum > {1'b0, cfg.trim_max}) ? cfg.trim_max : sum[7:0];
            end
         end
         default: begin
            trim = (trim >= cfg.step_down) ? trim - cfg.step_down : 8'd0;
         end
      endcase
      st.drive_cw    = (pwm_count < speed_reg) && (dir_reg == DIR_CW);
      st.drive_ccw   = (pwm_count < speed_reg) && (dir_reg == DIR_CCW);
      st.speed_now   = speed_reg;
      st.dir_code    = dir_reg;
      st.alarm_level = speed_band(speed_reg);
      st.trip_flag   = trip_latch;
      return st;
   endfunction

   always @(posedge clock) begin
      motor_status_type got;
      motor_status_type want;
      item_type         it;
      if (reset) begin
         cfg = '{wrap_period: 8'd254, warn_level: 8'd245, trip_level: 8'd252,
                 trip_count: 8'd100, step_up: 8'd8, step_down: 8'd2, trim_max: 8'd128};
         pwm_count  = 8'd0;
         trim       = 8'd0;
         speed_reg  = 8'd0;
         over_count = 8'd0;
         dir_reg    = DIR_NONE;
         trip_latch = 1'b0;
         status_queue.delete();
         fail_count = 0;
      end else begin
         // responses first, a transaction never answers on its own accept edge
         if (rsp_tvalid && rsp_tready) begin
            if (status_queue.size() == 0) begin
               report_mismatch($sformatf("response %h with nothing outstanding", rsp_tdata));
            end else begin
               want = status_queue.pop_front();
               got  = motor_status_type'(rsp_tdata[14:0]);
               compare_field("drive_cw", int'(got.drive_cw), int'(want.drive_cw));
               compare_field("drive_ccw", int'(got.drive_ccw), int'(want.drive_ccw));
               compare_field("speed_now", int'(got.speed_now), int'(want.speed_now));
               compare_field("dir_code", int'(got.dir_code), int'(want.dir_code));
               compare_field("alarm_level", int'(got.alarm_level), int'(want.alarm_level));
               compare_field("trip_flag", int'(got.trip_flag), int'(want.trip_flag));
               compare_field("pad", int'(rsp_tdata[15]), 0);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_WRAP_PERIOD: cfg.wrap_period = csr_wdata;
               REG_WARN_LEVEL:  cfg.warn_level  = csr_wdata;
               REG_TRIP_LEVEL:  cfg.trip_level  = csr_wdata;
               REG_TRIP_COUNT:  cfg.trip_count  = csr_wdata;
               REG_STEP_UP:     cfg.step_up     = csr_wdata;
               REG_STEP_DOWN:   cfg.step_down   = csr_wdata;
               REG_TRIM_MAX:    cfg.trim_max    = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            it.kind       = req_tuser;
            it.adc_sample = req_tdata[7:0];
            it.cw_select  = req_tdata[8];
            it.ccw_select = req_tdata[9];
            status_queue.push_back(advance_motor(it));
         end
      end
      pending = status_queue.size();
   end

endmodule

[test/tb.sv]
// testbench top for the pwm motor speed controller: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb;
   import pmsc_pkg::*;

   localparam int RSP_DATA_BITS = 16;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_ITEMS   = 175;
   localparam int STALL_CYCLES  = 64;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata;
   logic [1:0]                req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   int fail_count;
   int pending;
   int send_idle_pct;   // chance in percent that the sender skips a cycle
   int recv_idle_pct;   // chance in percent that the receiver drops tready
   int stall_asked;     // bumped by the stimulus to ask for one long receiver hold-off
   int stall_taken;     // owned by the receiver process
   int cycle_count;

   pwm_motor_speed_controller_top #(
      .SPEED_BITS (8)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   pmsc_tb_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit, far above the slowest legal run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // receiver: random tready, or a long hold-off when one is asked for
   initial begin
      rsp_tready  = 1'b0;
      stall_taken = 0;
      forever begin
         @(negedge clock);
         if (stall_asked != stall_taken) begin
            stall_taken = stall_asked;
            rsp_tready <= 1'b0;
            // hold long enough for the block to back up and drop req_tready
            repeat (STALL_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // one request transaction, with random idle cycles ahead of it; ends on a falling edge
   task automatic send_item(input logic [1:0] kind, input logic [7:0] adc,
                            input logic cw, input logic ccw);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'b0, ccw, cw, adc};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // random transaction; sample_pct sets how often it is a speed sample
   task automatic send_random(input int sample_pct);
      logic [1:0] kind;
      logic       cw;
      logic       ccw;
      int         pick;
      pick = $urandom_range(9);
      if ($urandom_range(99) < sample_pct)
         kind = KIND_SAMPLE;
      else if (pick < 5)
         kind = KIND_TICK;
      else if (pick < 8)
         kind = KIND_FASTER;
      else
         kind = KIND_SLOWER;
      // mostly a clean direction so that faster presses take effect
      if ($urandom_range(9) < 7) begin
         cw  = 1'($urandom_range(1));
         ccw = !cw;
      end else begin
         cw  = 1'($urandom_range(1));
         ccw = 1'($urandom_range(1));
      end
      send_item(kind, 8'($urandom_range(255)), cw, ccw);
   endtask

   // stop sending and wait until every response is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      // margin before going on
      repeat (2) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // full register set, only written with the block idle
   task automatic write_config(input logic [7:0] period, input logic [7:0] warn,
                               input logic [7:0] trip, input logic [7:0] count,
                               input logic [7:0] up, input logic [7:0] down,
                               input logic [7:0] tmax);
      drain();
      write_reg(REG_WRAP_PERIOD, period);
      write_reg(REG_WARN_LEVEL, warn);
      write_reg(REG_TRIP_LEVEL, trip);
      write_reg(REG_TRIP_COUNT, count);
      write_reg(REG_STEP_UP, up);
      write_reg(REG_STEP_DOWN, down);
      write_reg(REG_TRIM_MAX, tmax);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int sample_pct;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = KIND_TICK;
      csr_valid     = 1'b0;
      csr_index     = REG_WRAP_PERIOD;
      csr_wdata     = '0;
      stall_asked   = 0;
      send_idle_pct = 28;
      recv_idle_pct = 45;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part on the reset register values
      send_item(KIND_TICK, 8'hFF, 1'b1, 1'b1);      // tick with junk in the unused fields
      send_item(KIND_SAMPLE, 8'h00, 1'b1, 1'b0);    // cw at zero speed, no drive
      send_item(KIND_FASTER, 8'h00, 1'b0, 1'b0);
      send_item(KIND_FASTER, 8'h00, 1'b0, 1'b0);
      send_item(KIND_SAMPLE, 8'hFF, 1'b0, 1'b1);    // ccw, top adc plus trim
      send_item(KIND_TICK, 8'h00, 1'b0, 1'b0);
      send_item(KIND_SAMPLE, 8'hFE, 1'b1, 1'b1);    // both switches, direction invalid
      send_item(KIND_FASTER, 8'h00, 1'b0, 1'b0);    // ignored while invalid
      send_item(KIND_SLOWER, 8'h00, 1'b0, 1'b0);
      send_item(KIND_SAMPLE, 8'h01, 1'b0, 1'b0);    // neither switch
      send_item(KIND_SAMPLE, 8'h80, 1'b1, 1'b0);
      send_item(KIND_TICK, 8'h55, 1'b0, 1'b1);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         // idle pattern: sender light / receiver heavy, swapped, then none
         if (p < 3) begin
            send_idle_pct = 28;
            recv_idle_pct = 45;
         end else if (p < 6) begin
            send_idle_pct = 45;
            recv_idle_pct = 28;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         sample_pct = 30;
         case (p)
            // upper extremes, trim pinned at zero
            0: write_config(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
            // every sample in the over band, no trip possible, largest steps
            1: write_config(8'd1, 8'd0, 8'd0, 8'd255, 8'd128, 8'd128, 8'd128);
            // period zero; over band continues so the over counter saturates
            2: write_config(8'd0, 8'd0, 8'd0, 8'd255, 8'($urandom_range(128)),
                            8'($urandom_range(128)), 8'd128);
            // warn level below trip level, trip on the first over-band sample
            7: write_config(8'($urandom_range(1, 40)), 8'd0, 8'd100, 8'd0, 8'd64, 8'd1,
                            8'd128);
            default: write_config((p % 2) ? 8'($urandom_range(1, 40))
                                          : 8'($urandom_range(1, 255)),
                                  8'($urandom_range(150, 255)), 8'($urandom_range(150, 255)),
                                  8'd255, 8'($urandom_range(128)), 8'($urandom_range(128)),
                                  8'($urandom_range(128)));
         endcase
         if (p == 1 || p == 2)
            sample_pct = 80;
         if (p == 1) begin
            // trim to its cap, full speed, then straight to the floor
            send_item(KIND_SAMPLE, 8'hFF, 1'b1, 1'b0);
            send_item(KIND_FASTER, 8'h00, 1'b0, 1'b0);
            send_item(KIND_SAMPLE, 8'hFF, 1'b1, 1'b0);
            send_item(KIND_SLOWER, 8'h00, 1'b0, 1'b0);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long receiver hold-off while the sender keeps offering
            if (p == 1 && n == 60)
               stall_asked++;
            // sender waits for every response before going on
            if (p == 4 && n == 90)
               drain();
            send_random(sample_pct);
         end
      end

      drain();
      repeat (4) @(negedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
